// ===== rtl/ppmrx_pkg.sv =====
// Shared types, register codes and stick arithmetic for the PPM receiver.
// No dependencies; the files that use these refer to them by scoped name.
package ppmrx_pkg;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_MIN_PULSE = 3'd0;
	localparam logic [2:0] REG_MAX_PULSE = 3'd1;
	localparam logic [2:0] REG_SYNC_GAP  = 3'd2;
	localparam logic [2:0] REG_CENTER    = 3'd3;
	localparam logic [2:0] REG_DEADZONE  = 3'd4;
	localparam logic [2:0] REG_FAILSAFE  = 3'd5;
	localparam logic [2:0] REG_WALK_SLOT = 3'd6;
	localparam logic [2:0] REG_TURN_SLOT = 3'd7;

	// Register reset values
	localparam logic [15:0] RST_MIN_PULSE = 16'd900;
	localparam logic [15:0] RST_MAX_PULSE = 16'd2100;
	localparam logic [15:0] RST_SYNC_GAP  = 16'd3000;
	localparam logic [15:0] RST_CENTER    = 16'd1500;
	localparam logic [9:0]  RST_DEADZONE  = 10'd30;
	localparam logic [31:0] RST_FAILSAFE  = 32'd100000;
	localparam logic [2:0]  RST_WALK_SLOT = 3'd1;
	localparam logic [2:0]  RST_TURN_SLOT = 3'd0;

	// Motion commands
	localparam logic [2:0] MOT_IDLE     = 3'd0;
	localparam logic [2:0] MOT_FORWARD  = 3'd1;
	localparam logic [2:0] MOT_BACKWARD = 3'd2;
	localparam logic [2:0] MOT_RIGHT    = 3'd3;
	localparam logic [2:0] MOT_LEFT     = 3'd4;

	localparam logic signed [16:0] STICK_MAX = 17'sd500;
	localparam logic signed [16:0] STICK_MIN = -17'sd500;
	localparam logic [31:0]        AGE_NONE  = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [15:0] min_pulse;
		logic [15:0] max_pulse;
		logic [15:0] sync_gap;
		logic [15:0] center;
		logic [9:0]  deadzone;
		logic [31:0] failsafe;
		logic [2:0]  walk_slot;
		logic [2:0]  turn_slot;
	} cfg_t;

	typedef struct packed {
		logic [31:0]        frame_age;
		logic               active;
		logic [2:0]         motion;
		logic signed [9:0]  turn;
		logic signed [9:0]  walk;
		logic [15:0]        slot_width;
	} res_t;

	// Pulse window check, inclusive on both ends
	function automatic logic width_ok(logic [31:0] w, logic [15:0] lo, logic [15:0] hi);
		return (w >= {16'd0, lo}) && (w <= {16'd0, hi});
	endfunction

	// Centered, deadzoned and clamped stick offset; 0 for an invalid width
	function automatic logic signed [9:0] stick_value(logic [15:0] w, logic [15:0] center,
		logic [9:0] dz, logic ok);
		logic signed [16:0] c;
		logic [16:0]        mag;
		c = $signed({1'b0, w}) - $signed({1'b0, center});
		mag = c[16] ? 17'(-c) : 17'(c);
		if (!ok || mag < {7'd0, dz})
			c = '0;
		else if (c > STICK_MAX)
			c = STICK_MAX;
		else if (c < STICK_MIN)
			c = STICK_MIN;
		return c[9:0];
	endfunction

endpackage

// ===== rtl/ppmrx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ppmrx_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/ppmrx_slot_bank.sv =====
// Channel width store: one RAM copy per read port, valid bits, write bypass.
// Depends on ppmrx_ram.
module ppmrx_slot_bank #(
	parameter int CHANNEL_COUNT = 8,
	localparam int AddrW = $clog2(CHANNEL_COUNT),
	localparam int Reads = 3
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [AddrW-1:0]       wr_addr,
	input  logic [15:0]            wr_data,
	input  logic                   rd_en,
	input  logic [Reads-1:0][2:0]  rd_slot,   // read, walk, turn
	output logic [Reads-1:0][15:0] rd_width
);

	localparam int ExtW = (AddrW > 3) ? AddrW : 3;

	logic [CHANNEL_COUNT-1:0] valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	for (genvar p = 0; p < Reads; p++) begin : g_port
		logic [ExtW-1:0]  slot_ext;
		logic [AddrW-1:0] addr;
		logic [AddrW-1:0] addr_q;
		logic             in_range_q;
		logic             hit_q;
		logic [15:0]      byp_q;
		logic [15:0]      ram_data;

		assign slot_ext = ExtW'(rd_slot[p]);
		assign addr     = slot_ext[AddrW-1:0];

		ppmrx_ram #(
			.WIDTH(16),
			.DEPTH(CHANNEL_COUNT)
		) u_ram (
			.clk     (clk),
			.wr_en   (wr_en),
			.wr_addr (wr_addr),
			.wr_data (wr_data),
			.rd_en   (rd_en),
			.rd_addr (addr),
			.rd_data (ram_data)
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				addr_q     <= '0;
				in_range_q <= 1'b0;
				hit_q      <= 1'b0;
			end else if (rd_en) begin
				addr_q     <= addr;
				in_range_q <= 32'(rd_slot[p]) < 32'(CHANNEL_COUNT);
				hit_q      <= wr_en && (wr_addr == addr);
			end
		end

		// write landing on the same edge as the read
		always_ff @(posedge clk) begin
			if (rd_en)
				byp_q <= wr_data;
		end

		always_comb begin
			if (!in_range_q)
				rd_width[p] = '0;
			else if (hit_q)
				rd_width[p] = byp_q;
			else if (valid_q[addr_q])
				rd_width[p] = ram_data;
			else
				rd_width[p] = '0;
		end
	end

endmodule

// ===== rtl/ppmrx_query.sv =====
// Status query: frame age, active flag, stick offsets and motion command.
// Depends on ppmrx_pkg.
module ppmrx_query (
	input  ppmrx_pkg::cfg_t  cfg,
	input  logic [31:0]      now,
	input  logic [31:0]      last_frame,
	input  logic             frame_seen,
	input  logic [15:0]      read_width,
	input  logic [15:0]      walk_width,
	input  logic [15:0]      turn_width,
	output ppmrx_pkg::res_t  res
);

	logic              walk_ok;
	logic              turn_ok;
	logic [31:0]       age;
	logic signed [9:0] walk;
	logic signed [9:0] turn;
	logic signed [9:0] walk_abs;
	logic signed [9:0] turn_abs;

	assign walk_ok = ppmrx_pkg::width_ok({16'd0, walk_width}, cfg.min_pulse, cfg.max_pulse);
	assign turn_ok = ppmrx_pkg::width_ok({16'd0, turn_width}, cfg.min_pulse, cfg.max_pulse);
	assign age     = frame_seen ? (now - last_frame) : ppmrx_pkg::AGE_NONE;

	assign walk = ppmrx_pkg::stick_value(walk_width, cfg.center, cfg.deadzone, walk_ok);
	assign turn = ppmrx_pkg::stick_value(turn_width, cfg.center, cfg.deadzone, turn_ok);
	assign walk_abs = walk[9] ? -walk : walk;
	assign turn_abs = turn[9] ? -turn : turn;

	always_comb begin
		res.slot_width = read_width;
		res.walk       = walk;
		res.turn       = turn;
		res.frame_age  = age;
		res.active     = frame_seen && (age <= cfg.failsafe) && walk_ok && turn_ok;
		// larger magnitude wins, walk on ties
		if (walk == 10'sd0 && turn == 10'sd0)
			res.motion = ppmrx_pkg::MOT_IDLE;
		else if (walk_abs >= turn_abs)
			res.motion = walk[9] ? ppmrx_pkg::MOT_BACKWARD : ppmrx_pkg::MOT_FORWARD;
		else
			res.motion = turn[9] ? ppmrx_pkg::MOT_LEFT : ppmrx_pkg::MOT_RIGHT;
	end

endmodule

// ===== rtl/ppm_receiver_motion_decoder.sv =====
// Top level of the PPM receiver and motion decoder.
// Depends on ppmrx_pkg, ppmrx_slot_bank (and ppmrx_ram) and ppmrx_query.
//
// Usage:
//  - Slave stream (s_*): one transaction per event. s_tuser is the request
//    kind (0 falling edge, 1 status query); s_tdata carries the timestamp and
//    the channel to read back.
//  - Master stream (m_*): one transaction per status query, none per edge.
//  - Config channel (cfg_*): always ready; write cfg_data to register
//    cfg_index. Write only while no transaction is in flight.
//  - Throughput: one transaction per cycle on s_*, edges and queries mixed,
//    while no query waits behind a stalled result. An item passes through the
//    input register; a query result then goes into the output register and
//    shows on m_*. The channel store is read on the accepting edge.
//  - Stall: a result waits in the output register while m_tready is low. A
//    query behind it waits in the input register and s_tready drops; edges
//    still move through, since they make no result.
//  - Reset: registers return to their defaults, all channels read as 0, no
//    frame has been seen (frame age all ones, active low), slot pointer 0.
//    No clearing pass; the block accepts items right after reset.
module ppm_receiver_motion_decoder #(
	parameter int CHANNEL_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] time_us, [34:32] read_slot, [39:35] zero
	input  logic        s_tuser,   // req_type
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [15:0] slot_width_us, [25:16] walk_value,
	                               // [35:26] turn_value, [38:36] motion,
	                               // [39] active, [71:40] frame_age_us
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int AddrW = $clog2(CHANNEL_COUNT);
	localparam int SlotW = $clog2(CHANNEL_COUNT + 1);   // pointer saturates at the count

	ppmrx_pkg::cfg_t cfg_q;

	logic        valid_s1;
	logic        req_s1;
	logic [31:0] time_s1;

	logic [31:0]      last_edge_q;
	logic [31:0]      last_frame_q;
	logic             frame_seen_q;
	logic [SlotW-1:0] next_slot_q;

	logic             out_valid_q;
	ppmrx_pkg::res_t  out_q;
	ppmrx_pkg::res_t  res;

	logic             accept;
	logic             out_free;
	logic             s1_go;
	logic             edge_fire;
	logic             query_fire;
	logic [31:0]      dur;
	logic             is_sync;
	logic             wr_en;
	logic [AddrW-1:0] wr_addr;
	logic [2:0][2:0]  rd_slot;
	logic [2:0][15:0] rd_width;

	// ---- configuration registers ----
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_pulse <= ppmrx_pkg::RST_MIN_PULSE;
			cfg_q.max_pulse <= ppmrx_pkg::RST_MAX_PULSE;
			cfg_q.sync_gap  <= ppmrx_pkg::RST_SYNC_GAP;
			cfg_q.center    <= ppmrx_pkg::RST_CENTER;
			cfg_q.deadzone  <= ppmrx_pkg::RST_DEADZONE;
			cfg_q.failsafe  <= ppmrx_pkg::RST_FAILSAFE;
			cfg_q.walk_slot <= ppmrx_pkg::RST_WALK_SLOT;
			cfg_q.turn_slot <= ppmrx_pkg::RST_TURN_SLOT;
		end else if (cfg_valid) begin
			case (cfg_index)
				ppmrx_pkg::REG_MIN_PULSE: cfg_q.min_pulse <= cfg_data[15:0];
				ppmrx_pkg::REG_MAX_PULSE: cfg_q.max_pulse <= cfg_data[15:0];
				ppmrx_pkg::REG_SYNC_GAP:  cfg_q.sync_gap  <= cfg_data[15:0];
				ppmrx_pkg::REG_CENTER:    cfg_q.center    <= cfg_data[15:0];
				ppmrx_pkg::REG_DEADZONE:  cfg_q.deadzone  <= cfg_data[9:0];
				ppmrx_pkg::REG_FAILSAFE:  cfg_q.failsafe  <= cfg_data;
				ppmrx_pkg::REG_WALK_SLOT: cfg_q.walk_slot <= cfg_data[2:0];
				ppmrx_pkg::REG_TURN_SLOT: cfg_q.turn_slot <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// ---- handshake ----
	// An edge in the input register never waits; a query there waits for the
	// output register to free up.
	assign out_free   = !out_valid_q || m_tready;
	assign s1_go      = !valid_s1 || !req_s1 || out_free;
	assign s_tready   = s1_go;
	assign accept     = s_tvalid && s_tready;
	assign edge_fire  = valid_s1 && !req_s1;
	assign query_fire = valid_s1 && req_s1 && out_free;

	// ---- input register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s1_go)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= s_tuser;
			time_s1 <= s_tdata[31:0];
		end
	end

	// ---- edge handling ----
	assign dur     = time_s1 - last_edge_q;    // wraps with the timestamp
	assign is_sync = dur > {16'd0, cfg_q.sync_gap};
	assign wr_en   = edge_fire && !is_sync
		&& ppmrx_pkg::width_ok(dur, cfg_q.min_pulse, cfg_q.max_pulse)
		&& (next_slot_q < SlotW'(CHANNEL_COUNT));
	assign wr_addr = next_slot_q[AddrW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_q  <= '0;
			last_frame_q <= '0;
			frame_seen_q <= 1'b0;
			next_slot_q  <= '0;
		end else if (edge_fire) begin
			last_edge_q <= time_s1;
			if (is_sync) begin
				next_slot_q  <= '0;
				last_frame_q <= time_s1;
				frame_seen_q <= 1'b1;
			end else if (wr_en) begin
				next_slot_q <= next_slot_q + SlotW'(1);
			end
		end
	end

	// ---- channel store, read on the accepting edge ----
	assign rd_slot[0] = s_tdata[34:32];
	assign rd_slot[1] = cfg_q.walk_slot;
	assign rd_slot[2] = cfg_q.turn_slot;

	ppmrx_slot_bank #(
		.CHANNEL_COUNT(CHANNEL_COUNT)
	) u_bank (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (dur[15:0]),
		.rd_en    (accept),
		.rd_slot  (rd_slot),
		.rd_width (rd_width)
	);

	// ---- query ----
	ppmrx_query u_query (
		.cfg        (cfg_q),
		.now        (time_s1),
		.last_frame (last_frame_q),
		.frame_seen (frame_seen_q),
		.read_width (rd_width[0]),
		.walk_width (rd_width[1]),
		.turn_width (rd_width[2]),
		.res        (res)
	);

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (query_fire)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (query_fire)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.frame_age, out_q.active, out_q.motion,
		out_q.turn, out_q.walk, out_q.slot_width};

endmodule

// ===== rtl/ppmrx_checker.sv =====
// Port-level checks for the PPM receiver, bound to the top level.
// Depends on ppmrx_pkg and ppm_receiver_motion_decoder.
module ppmrx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata
);

	logic              query_acc;
	logic signed [9:0] walk;
	logic signed [9:0] turn;
	logic [2:0]        motion;

	assign query_acc = s_tvalid && s_tready && s_tuser;
	assign walk      = m_tdata[25:16];
	assign turn      = m_tdata[35:26];
	assign motion    = m_tdata[38:36];

	// a result appears only after a query was taken
	a_rise_after_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(query_acc, 2))
		else $error("result without a query");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// idle exactly when both sticks are zero
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((motion == ppmrx_pkg::MOT_IDLE) == (walk == 10'sd0 && turn == 10'sd0)))
		else $error("motion does not match stick values");

	// clamp
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (walk <= 10'sd500 && walk >= -10'sd500
			&& turn <= 10'sd500 && turn >= -10'sd500))
		else $error("stick value out of range");

endmodule

bind ppm_receiver_motion_decoder ppmrx_checker u_ppmrx_checker (.*);
